// ===== hdl/assert_macros.svh =====
// Assertion shorthands for the deque checker.
// All checks sample on i_clk and are held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define WSD_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("deque check failed");

// Condition must hold in the cycle after the trigger.
`define WSD_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("deque check failed");

`endif

// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

    localparam int TASK_W = 32;
    localparam int ACT_W  = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_STEAL = 3'd2,
        ACT_PEEK  = 3'd3,
        ACT_CLEAR = 3'd4
    } t_action;

endpackage

// ===== hdl/work_stealing_deque_top.sv =====
// An accepted word is held in stage 1, then moves to the output register and o_valid.
// Throughput: one word per cycle; pointers live in registers and the ring is a
// single memory with one write and one registered read port, so a new word
// enters every cycle while the output register is free or being emptied.
// Reset (synchronous, active low): front and back pointers zero, pipeline empty;
// ring contents are left as they are and only entries between front and back are read.
module work_stealing_deque_top #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [wsd_pkg::ACT_W-1:0]  i_action,
    input  logic [wsd_pkg::TASK_W-1:0] i_task_req,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_ok,
    output logic [wsd_pkg::TASK_W-1:0] o_task_out,
    output logic [$clog2(DEPTH):0]     o_count,
    output logic                       o_is_empty,
    output logic                       o_is_full
);
    import wsd_pkg::*;

    // Pointers count positions modulo 2*DEPTH so that full and empty differ;
    // the low AW bits index the ring.
    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    // ring storage
    logic [TASK_W-1:0] r_mem [DEPTH];
    logic [TASK_W-1:0] r_rd_data;

    // pointers
    logic [PW-1:0] r_front, n_front;
    logic [PW-1:0] r_back,  n_back;

    // stage 1: memory read in flight
    logic          r_s1_v;
    logic          r_s1_ok;
    logic          r_s1_rd;    // result takes the word read from the ring
    logic [PW-1:0] r_s1_cnt;

    // stage 2: output register
    logic              r_o_v;
    logic              r_o_ok;
    logic [TASK_W-1:0] r_o_task;
    logic [PW-1:0]     r_o_cnt;
    logic              r_o_empty;
    logic              r_o_full;

    t_action       w_act;
    logic          w_acc;
    logic          w_s1_adv;
    logic [PW-1:0] w_held;
    logic [PW-1:0] w_back_m1;
    logic          w_ok;
    logic          w_rd_en;
    logic          w_wr_en;
    logic [AW-1:0] w_rd_addr;
    logic [PW-1:0] w_cnt_next;

    assign w_act     = t_action'(i_action);
    assign w_held    = r_back - r_front;
    assign w_back_m1 = r_back - PW'(1);

    // Stage 1 moves on when the output register is empty or being drained.
    assign w_s1_adv = r_s1_v & (~r_o_v | i_ready);
    assign o_ready  = ~r_s1_v | ~r_o_v | i_ready;
    assign w_acc    = i_valid & o_ready;

    // Decode the access and work out the new pointers.
    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        w_ok      = 1'b0;
        w_rd_en   = 1'b0;
        w_wr_en   = 1'b0;
        w_rd_addr = r_front[AW-1:0];
        unique case (w_act)
            ACT_PUSH: begin
                if (w_held != DEPTH_P) begin
                    w_wr_en = 1'b1;
                    n_back  = r_back + PW'(1);
                    w_ok    = 1'b1;
                end
            end
            ACT_POP: begin
                if (w_held != '0) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_back_m1[AW-1:0];
                    w_ok      = 1'b1;
                    // last entry out: both pointers step past the old front
                    if (w_held == PW'(1)) begin
                        n_front = r_front + PW'(1);
                        n_back  = r_front + PW'(1);
                    end else begin
                        n_back  = w_back_m1;
                    end
                end
            end
            ACT_STEAL: begin
                if (w_held != '0) begin
                    w_rd_en = 1'b1;
                    n_front = r_front + PW'(1);
                    w_ok    = 1'b1;
                end
            end
            ACT_PEEK: begin
                if (w_held != '0) begin
                    w_rd_en = 1'b1;
                    w_ok    = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_front = '0;
                n_back  = '0;
                w_ok    = 1'b1;
            end
            default: begin
                // undefined action: no change, ok low
            end
        endcase
    end

    assign w_cnt_next = n_back - n_front;

    // Ring memory: one write, one registered read. A push followed by a pop of the
    // same slot reads after the write edge, so no bypass is needed.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_wr_en) begin
            r_mem[r_back[AW-1:0]] <= i_task_req;
        end
        if (w_acc && w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Pointers and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_s1_v  <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            if (w_acc) begin
                r_front <= n_front;
                r_back  <= n_back;
            end
            if (w_acc) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_adv) begin
                r_o_v <= 1'b1;
            end else if (i_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_ok  <= w_ok;
            r_s1_rd  <= w_rd_en;
            r_s1_cnt <= w_cnt_next;
        end
        if (w_s1_adv) begin
            r_o_ok    <= r_s1_ok;
            r_o_task  <= r_s1_rd ? r_rd_data : '0;
            r_o_cnt   <= r_s1_cnt;
            r_o_empty <= (r_s1_cnt == '0);
            r_o_full  <= (r_s1_cnt == DEPTH_P);
        end
    end

    assign o_valid    = r_o_v;
    assign o_ok       = r_o_ok;
    assign o_task_out = r_o_task;
    assign o_count    = r_o_cnt;
    assign o_is_empty = r_o_empty;
    assign o_is_full  = r_o_full;

endmodule

// ===== hdl/wsd_checker.sv =====
`include "assert_macros.svh"

module wsd_checker #(
    parameter int DEPTH = 64
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_ok,
    input logic [wsd_pkg::TASK_W-1:0] o_task_out,
    input logic [$clog2(DEPTH):0]     o_count,
    input logic                       o_is_empty,
    input logic                       o_is_full
);
    import wsd_pkg::*;

    localparam int PW = $clog2(DEPTH) + 1;
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    // a stalled result word stays offered
    `WSD_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    // status flags agree with the count
    `WSD_ASSERT_NOW(a_empty_flag, o_valid, o_is_empty == (o_count == '0))
    `WSD_ASSERT_NOW(a_full_flag, o_valid, o_is_full == (o_count == DEPTH_P))
    // count never exceeds the ring size
    `WSD_ASSERT_NOW(a_count_range, o_valid, o_count <= DEPTH_P)
    // a refused access returns no handle
    `WSD_ASSERT_NOW(a_task_zero, o_valid && !o_ok, o_task_out == '0)

endmodule

bind work_stealing_deque_top wsd_checker #(.DEPTH(DEPTH)) u_wsd_checker (.*);

// ===== test/work_stealing_deque_top_tb.sv =====
`timescale 1ns / 1ps

module work_stealing_deque_top_tb;

    import wsd_pkg::*;

    localparam int DEPTH = 64;
    localparam int PW    = $clog2(DEPTH) + 1;   // positions run modulo 2*DEPTH

    // Codes outside the action enum; the block must leave the deque alone for these
    localparam logic [ACT_W-1:0] ACT_UNKNOWN_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN_MID   = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN_LAST  = 3'd7;

    // One result word as the block should present it
    typedef struct {
        logic              ok;
        logic [TASK_W-1:0] task_out;
        logic [PW-1:0]     count;
        logic              is_empty;
        logic              is_full;
    } t_deque_reply;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [ACT_W-1:0]  i_action;
    logic [TASK_W-1:0] i_task_req;
    logic              o_valid;
    logic              i_ready;
    logic              o_ok;
    logic [TASK_W-1:0] o_task_out;
    logic [PW-1:0]     o_count;
    logic              o_is_empty;
    logic              o_is_full;

    // Shadow copy of the deque, advanced once per accepted request word
    logic [TASK_W-1:0] shadow_ring [DEPTH];
    logic [PW-1:0]     shadow_front;
    logic [PW-1:0]     shadow_back;

    t_deque_reply      owed_replies[$];   // replies still to come, oldest first
    int unsigned       mismatch_count;

    // Idling switches; tests turn them off for stretches at full rate
    bit                send_gaps_on;
    bit                recv_stalls_on;
    int unsigned       recv_hold;

    work_stealing_deque_top #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_task_req (i_task_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_ok       (o_ok),
        .o_task_out (o_task_out),
        .o_count    (o_count),
        .o_is_empty (o_is_empty),
        .o_is_full  (o_is_full)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: far beyond the slowest legal run (~700 words, each with a long
    // send gap, a long receive stall and the pipeline latency)
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    function automatic logic [PW-1:0] shadow_held();
        return shadow_back - shadow_front;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Apply one access to the shadow deque and queue the reply it owes
    task automatic model_deque_access(input logic [ACT_W-1:0] act, input logic [TASK_W-1:0] req);
        t_deque_reply  reply;
        logic [PW-1:0] held;
        logic [PW-1:0] last_pos;
        held           = shadow_held();
        reply.ok       = 1'b0;
        reply.task_out = '0;
        case (act)
            ACT_PUSH: begin
                if (held != DEPTH) begin
                    shadow_ring[shadow_back[PW-2:0]] = req;
                    shadow_back = shadow_back + 1'b1;
                    reply.ok = 1'b1;
                end
            end
            ACT_POP: begin
                if (held != 0) begin
                    last_pos       = shadow_back - 1'b1;
                    reply.task_out = shadow_ring[last_pos[PW-2:0]];
                    reply.ok       = 1'b1;
                    // taking the last entry parks both ends one past the old front
                    if (held == 1) begin
                        shadow_front = shadow_front + 1'b1;
                        shadow_back  = shadow_front;
                    end else begin
                        shadow_back = last_pos;
                    end
                end
            end
            ACT_STEAL: begin
                if (held != 0) begin
                    reply.task_out = shadow_ring[shadow_front[PW-2:0]];
                    shadow_front   = shadow_front + 1'b1;
                    reply.ok       = 1'b1;
                end
            end
            ACT_PEEK: begin
                if (held != 0) begin
                    reply.task_out = shadow_ring[shadow_front[PW-2:0]];
                    reply.ok       = 1'b1;
                end
            end
            ACT_CLEAR: begin
                shadow_front = '0;
                shadow_back  = '0;
                reply.ok     = 1'b1;
            end
            default: begin
                // unknown codes: no change, status only
            end
        endcase
        held           = shadow_held();
        reply.count    = held;
        reply.is_empty = (held == 0);
        reply.is_full  = (held == DEPTH);
        owed_replies.push_back(reply);
    endtask

    // Present one request word at the falling edge and hold it until taken
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [TASK_W-1:0] req);
        int unsigned gap;
        gap = send_gaps_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_action   = act;
        i_task_req = req;
        do
            @(posedge i_clk);
        while (!o_ready);
        model_deque_access(act, req);
    endtask

    task automatic release_sender();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Sender holds off until every owed reply is back
    task automatic wait_drained();
        release_sender();
        while (owed_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_access(input int unsigned push_pct, input int unsigned take_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            send_word(ACT_PUSH, $urandom());
        else if (roll < push_pct + take_pct)
            send_word($urandom_range(0, 1) ? ACT_POP : ACT_STEAL, $urandom());
        else if (roll < push_pct + take_pct + 12)
            send_word(ACT_PEEK, $urandom());
        else if (roll < push_pct + take_pct + 16)
            send_word(ACT_CLEAR, $urandom());
        else
            send_word(ACT_W'($urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST)),
                      $urandom());
    endtask

    // Receiver: ready in runs of random length, stalls of random length between
    always @(negedge i_clk) begin
        if (recv_hold != 0) begin
            recv_hold--;
        end else if (i_ready && recv_stalls_on) begin
            i_ready   = 1'b0;
            recv_hold = pick_gap();
        end else begin
            i_ready   = 1'b1;
            recv_hold = $urandom_range(0, 12);
        end
    end

    // Every reply word is held against the oldest owed reply, field by field
    always @(posedge i_clk) begin
        t_deque_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_replies.size() == 0) begin
                report_mismatch("reply word with nothing owed");
            end else begin
                want = owed_replies.pop_front();
                if (o_ok !== want.ok)
                    report_mismatch($sformatf("ok %0b, want %0b", o_ok, want.ok));
                if (o_task_out !== want.task_out)
                    report_mismatch($sformatf("task_out %h, want %h",
                                              o_task_out, want.task_out));
                if (o_count !== want.count)
                    report_mismatch($sformatf("count %0d, want %0d", o_count, want.count));
                if (o_is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty %0b, want %0b",
                                              o_is_empty, want.is_empty));
                if (o_is_full !== want.is_full)
                    report_mismatch($sformatf("is_full %0b, want %0b",
                                              o_is_full, want.is_full));
            end
        end
    end

    // Accesses on an empty deque, including an unknown code
    task automatic test_empty_accesses();
        send_word(ACT_PEEK, 32'hFFFF_FFFF);
        send_word(ACT_POP, 32'h0000_0000);
        send_word(ACT_STEAL, $urandom());
        send_word(ACT_UNKNOWN_FIRST, $urandom());
    endtask

    // Extreme handles, pop of the sole entry, pop versus steal order, clear, unknown codes
    task automatic test_directed_edges();
        send_word(ACT_PUSH, 32'hFFFF_FFFF);
        send_word(ACT_PEEK, 32'h0000_0000);
        send_word(ACT_POP, $urandom());          // last entry: both ends move on
        send_word(ACT_PUSH, 32'h0000_0000);
        send_word(ACT_PUSH, 32'hA5A5_5A5A);
        send_word(ACT_PUSH, 32'h5A5A_A5A5);
        send_word(ACT_STEAL, $urandom());        // front: the zero handle
        send_word(ACT_POP, $urandom());          // back: 5A5AA5A5
        send_word(ACT_UNKNOWN_LAST, $urandom()); // one entry left, untouched
        send_word(ACT_UNKNOWN_MID, $urandom());
        send_word(ACT_PEEK, $urandom());
        send_word(ACT_CLEAR, $urandom());        // clear with an entry held
        send_word(ACT_CLEAR, $urandom());        // clear when already empty
        send_word(ACT_PUSH, 32'h0000_0001);
        send_word(ACT_STEAL, $urandom());        // steal of the sole entry
        send_word(ACT_PUSH, 32'h8000_0000);
    endtask

    // Fill past full (extra pushes refused), then drain past empty
    task automatic test_fill_and_drain();
        while (shadow_held() != DEPTH)
            send_word(ACT_PUSH, $urandom());
        repeat ($urandom_range(1, 3))
            send_word(ACT_PUSH, $urandom());
        send_word(ACT_PEEK, $urandom());
        while (shadow_held() != 0)
            send_word($urandom_range(0, 1) ? ACT_POP : ACT_STEAL, $urandom());
        repeat ($urandom_range(1, 3))
            send_word($urandom_range(0, 1) ? ACT_POP : ACT_STEAL, $urandom());
    endtask

    // Mixed traffic in stretches; push bias follows the fill so both ends get visited
    task automatic test_random_mix(input int unsigned words);
        for (int unsigned n = 0; n < words; n++) begin
            if (n % 60 == 0) begin
                send_gaps_on   = $urandom_range(0, 3) != 0;
                recv_stalls_on = $urandom_range(0, 3) != 0;
            end
            if (shadow_held() > DEPTH - 8)
                send_random_access(25, 55);
            else if (shadow_held() < 8)
                send_random_access(60, 20);
            else
                send_random_access(42, 38);
        end
    endtask

    initial begin
        mismatch_count = 0;
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        recv_hold      = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_PUSH;
        i_task_req     = '0;
        i_ready        = 1'b1;
        shadow_front   = '0;
        shadow_back    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_accesses();
        test_directed_edges();
        wait_drained();

        // first pass at full rate on both sides, second with idling
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        test_fill_and_drain();
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        test_fill_and_drain();
        wait_drained();

        test_random_mix(360);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
